### hw/rtl/lzwe_pkg.sv
// Shared constants for the LZW byte encoder.
package lzwe_pkg;

  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 13;
  localparam int FIRST_CODE = 256;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

endpackage

### hw/rtl/lzw_byte_encoder_top.sv
// LZW byte-stream encoder with a memory-based trie child table.
//
// One byte per input item (in_tdata), in_tlast marks the last byte of a stream.
// Output items carry one phrase code each (out_tdata), out_tlast marks the final
// code of a stream; an item causes zero, one or two output items. Codes 0..255
// are the single bytes, new phrases are numbered from 256 up to one below the
// effective limit min(dict_limit, NUM_CODES), after which the dictionary is
// frozen. dict_limit is written through the cfg_ channel (always ready) and
// takes effect on the next miss.
// Input rate: no new input item is taken in S_RD, only in S_IDLE or S_DEC. The
// loop that sets this is the prefix update: the child table read feeds an
// entry-address table read, and the compare that decides the next prefix
// drives the child table address of the following item in the same cycle.
// Memories: child table NUM_CODES*256 x clog2(NUM_CODES) bits, entry table
// NUM_CODES x (clog2(NUM_CODES)+8) bits. Neither is ever cleared: a child
// read from the table counts only if its code was handed out in the current
// stream (256 <= code < next_free) and the entry table confirms it was made
// for this very (prefix, byte) slot. End of stream just resets next_free, so
// there is no clearing pass, after reset or between streams.
// Results leave through a 4-entry queue, one per cycle while out_tready is
// high; a new item is taken while earlier results wait there, if room for two remains.
module lzw_byte_encoder_top #(
  parameter int CODE_BITS = 12,
  parameter int NUM_CODES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write: dict_limit
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lzwe_pkg::LIMIT_W-1:0]         cfg_data,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lzwe_pkg::BYTE_W-1:0]          in_tdata,   // [7:0] in_byte
  input  logic                                 in_tlast,   // end_of_stream
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((CODE_BITS+7)/8)*8-1:0]       out_tdata,  // [CODE_BITS-1:0] code, zero pad
  output logic                                 out_tlast   // last
);
  import lzwe_pkg::*;

  localparam int AW    = $clog2(NUM_CODES);            // code width inside
  localparam int TW    = AW + BYTE_W;                  // child table address
  localparam int NFW   = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;
  localparam int OUT_W = ((CODE_BITS + 7) / 8) * 8;
  localparam int QD    = 4;                            // result queue depth

  typedef enum logic [1:0] {S_IDLE, S_RD, S_DEC} state_t;

  typedef struct packed {
    logic                 last;
    logic [CODE_BITS-1:0] code;
  } res_t;

  // control / state registers
  state_t            state_r, state_nxt;
  logic [AW-1:0]     pfx_r, pfx_nxt;
  logic              pv_r, pv_nxt;
  logic [NFW-1:0]    nf_r, nf_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [1:0]        head_r, tail_r;
  logic [2:0]        cnt_r, cnt_nxt;

  // item in flight
  logic [BYTE_W-1:0] byte_r;
  logic              eos_r;
  logic [TW-1:0]     idx_r;
  logic [AW-1:0]     child_r;

  // memories
  logic [AW-1:0]     ct_mem [NUM_CODES*256];
  logic [TW-1:0]     ea_mem [NUM_CODES];
  logic [AW-1:0]     ct_rd_r;
  logic [TW-1:0]     ea_rd_r;
  logic [TW-1:0]     ct_ra;
  logic [AW-1:0]     ea_ra;
  logic              wr_en;
  logic              fwd_hit_r;
  logic [AW-1:0]     fwd_d_r;
  logic [AW-1:0]     child;

  // result queue
  res_t              q_mem [QD];
  res_t              e0, e1;
  logic [1:0]        npush;

  logic              acc, pop, hit;
  logic [NFW-1:0]    lim_eff;
  logic [2:0]        room_sum;

  assign cfg_ready = 1'b1;

  assign lim_eff = (NFW'(limit_r) > NFW'(NUM_CODES)) ? NFW'(NUM_CODES) : NFW'(limit_r);

  // child read with same-edge write forwarding
  assign child = fwd_hit_r ? fwd_d_r : ct_rd_r;
  assign ea_ra = child;

  assign hit = (child_r >= AW'(FIRST_CODE)) && (NFW'(child_r) < nf_r) &&
               (ea_rd_r == idx_r);

  // decide step
  always_comb begin
    pfx_nxt = pfx_r;
    pv_nxt  = pv_r;
    nf_nxt  = nf_r;
    wr_en   = 1'b0;
    npush   = 2'd0;
    e0      = '0;
    e1      = '0;
    if (state_r == S_DEC) begin
      if (!pv_r) begin
        pfx_nxt = AW'(byte_r);
        pv_nxt  = 1'b1;
      end else if (hit) begin
        pfx_nxt = child_r;
      end else begin
        e0.code = CODE_BITS'(pfx_r);
        e0.last = 1'b0;
        npush   = 2'd1;
        if (nf_r < lim_eff) begin
          wr_en  = 1'b1;
          nf_nxt = nf_r + NFW'(1);
        end
        pfx_nxt = AW'(byte_r);
      end
      if (eos_r) begin
        if (npush == 2'd1) begin
          e1.code = CODE_BITS'(pfx_nxt);
          e1.last = 1'b1;
          npush   = 2'd2;
        end else begin
          e0.code = CODE_BITS'(pfx_nxt);
          e0.last = 1'b1;
          npush   = 2'd1;
        end
        pfx_nxt = '0;
        pv_nxt  = 1'b0;
        nf_nxt  = NFW'(FIRST_CODE);
      end
    end
  end

  // accept only when two more results are sure to fit at decide time
  assign room_sum  = cnt_r + {1'b0, npush};
  assign in_tready = (state_r != S_RD) && (room_sum <= 3'(QD - 2));
  assign acc       = in_tvalid && in_tready;
  assign ct_ra     = {pfx_nxt, in_tdata};

  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = OUT_W'(q_mem[head_r].code);
  assign out_tlast  = q_mem[head_r].last;
  assign cnt_nxt    = room_sum - {2'b00, pop};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc) state_nxt = S_RD;
      S_RD:    state_nxt = S_DEC;
      S_DEC:   state_nxt = acc ? S_RD : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pfx_r   <= '0;
      pv_r    <= 1'b0;
      nf_r    <= NFW'(FIRST_CODE);
      limit_r <= LIMIT_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pfx_r   <= pfx_nxt;
      pv_r    <= pv_nxt;
      nf_r    <= nf_nxt;
      if (cfg_valid) limit_r <= cfg_data;
      tail_r  <= tail_r + npush;
      if (pop) head_r <= head_r + 2'd1;
      cnt_r   <= cnt_nxt;
    end
  end

  // item payload, no reset
  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r <= in_tdata;
      eos_r  <= in_tlast;
      idx_r  <= ct_ra;
    end
    if (state_r == S_RD) child_r <= child;
    fwd_hit_r <= wr_en && (idx_r == ct_ra);
    fwd_d_r   <= nf_r[AW-1:0];
  end

  // child table: (prefix, byte) -> child code
  always_ff @(posedge clk) begin
    if (wr_en) ct_mem[idx_r] <= nf_r[AW-1:0];
    ct_rd_r <= ct_mem[ct_ra];
  end

  // entry table: code -> slot it was made for
  always_ff @(posedge clk) begin
    if (wr_en) ea_mem[nf_r[AW-1:0]] <= idx_r;
    ea_rd_r <= ea_mem[ea_ra];
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (npush != 2'd0) q_mem[tail_r] <= e0;
    if (npush == 2'd2) q_mem[tail_r + 2'd1] <= e1;
  end

endmodule
